[rtl/core/move_to_front_codec_top_defines.svh]
// Assertion shorthands for the move-to-front codec.
// All of them are clocked on clk_i and disabled while rst_ni is low.
`ifndef MOVE_TO_FRONT_CODEC_TOP_DEFINES_SVH
`define MOVE_TO_FRONT_CODEC_TOP_DEFINES_SVH

// Same-cycle implication.
`define MTFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("move_to_front_codec: same-cycle check failed");

// Next-cycle implication.
`define MTFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("move_to_front_codec: next-cycle check failed");

`endif

[rtl/core/mtfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mtfc_pkg;

  // Default list length.
  localparam int unsigned ALPHABET_SIZE = 128;

  // Width of the value_out field.
  localparam int unsigned VALUE_OUT_W = 7;

  // Control part of the token that walks the cell chain.
  typedef struct packed {
    logic valid;       // token present in this stage
    logic write_pass;  // 1: move-to-front pass, 0: read-only lookup pass
    logic done;        // target found upstream, later cells pass it through
  } tok_ctl_t;

endpackage

`default_nettype wire

[rtl/core/mtfc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mtfc_cell #(
  parameter int unsigned SymW = 7,
  parameter int unsigned Idx  = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              restore_i,
  input  wire mtfc_pkg::tok_ctl_t ctl_i,
  input  wire logic [SymW-1:0]   key_i,
  input  wire logic [SymW-1:0]   carry_i,
  input  wire logic [SymW-1:0]   result_i,
  output      mtfc_pkg::tok_ctl_t ctl_o,
  output      logic [SymW-1:0]   key_o,
  output      logic [SymW-1:0]   carry_o,
  output      logic [SymW-1:0]   result_o
);

  localparam logic [SymW-1:0] IdxSym = SymW'(Idx);

  logic [SymW-1:0]    sym_q, sym_d;
  mtfc_pkg::tok_ctl_t ctl_q, ctl_d;
  logic [SymW-1:0]    key_q, key_d;
  logic [SymW-1:0]    carry_q, carry_d;
  logic [SymW-1:0]    result_q, result_d;

  // Update this entry and the passing token
  always_comb begin
    sym_d    = sym_q;
    ctl_d    = ctl_i;
    key_d    = key_i;
    carry_d  = carry_i;
    result_d = result_i;
    if (restore_i) begin
      sym_d = IdxSym;
    end else if (ctl_i.valid && !ctl_i.done) begin
      if (ctl_i.write_pass) begin
        // take the entry from the front side, hand ours on
        sym_d   = carry_i;
        carry_d = sym_q;
        if (sym_q == key_i) begin
          ctl_d.done = 1'b1;
          result_d   = IdxSym;
        end
      end else if (key_i == IdxSym) begin
        // lookup: report the symbol held at this position
        ctl_d.done = 1'b1;
        result_d   = sym_q;
      end
    end
  end

  // Hold list entry and token control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= IdxSym;
      ctl_q <= '0;
    end else begin
      sym_q <= sym_d;
      ctl_q <= ctl_d;
    end
  end

  // Advance token payload
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    carry_q  <= carry_d;
    result_q <= result_d;
  end

  assign ctl_o    = ctl_q;
  assign key_o    = key_q;
  assign carry_o  = carry_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

[rtl/core/mtfc_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

module mtfc_chain #(
  parameter int unsigned AlphabetSize = mtfc_pkg::ALPHABET_SIZE,
  parameter int unsigned SymW         = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              restore_i,
  input  wire mtfc_pkg::tok_ctl_t ctl_i,
  input  wire logic [SymW-1:0]   key_i,
  input  wire logic [SymW-1:0]   carry_i,
  output      mtfc_pkg::tok_ctl_t ctl_o,
  output      logic [SymW-1:0]   result_o
);

  mtfc_pkg::tok_ctl_t ctl_w    [AlphabetSize+1];
  logic [SymW-1:0]    key_w    [AlphabetSize+1];
  logic [SymW-1:0]    carry_w  [AlphabetSize+1];
  logic [SymW-1:0]    result_w [AlphabetSize+1];

  // Feed the token into the front cell
  assign ctl_w[0]    = ctl_i;
  assign key_w[0]    = key_i;
  assign carry_w[0]  = carry_i;
  assign result_w[0] = '0;

  // Row of list cells, position 0 at the front
  for (genvar g = 0; g < AlphabetSize; g++) begin : g_cell
    mtfc_cell #(
      .SymW (SymW),
      .Idx  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .restore_i (restore_i),
      .ctl_i     (ctl_w[g]),
      .key_i     (key_w[g]),
      .carry_i   (carry_w[g]),
      .result_i  (result_w[g]),
      .ctl_o     (ctl_w[g+1]),
      .key_o     (key_w[g+1]),
      .carry_o   (carry_w[g+1]),
      .result_o  (result_w[g+1])
    );
  end

  // Token leaves at the back cell
  assign ctl_o    = ctl_w[AlphabetSize];
  assign result_o = result_w[AlphabetSize];

endmodule

`default_nettype wire

[rtl/core/move_to_front_codec_top.sv]
// Move-to-front codec over a list of ALPHABET_SIZE symbols held one per cell in a
// row of cells. An item walks the row as a token, one cell per clock, and the row
// shifts entries back behind it as it goes. Items are handled one at a time: an
// encode item walks the row once, a decode item walks it twice because it first
// walks the row to look up the symbol and then walks it again to move that symbol
// to the front, and an out-of-range value does not enter the row. A result
// waiting in the output register does not block the next input transfer. A
// start_of_message item restores identity order in all cells in the cycle of its
// transfer. Write cfg_decode_mode_i (0 encode, 1 decode) only while the block is
// idle.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_codec_top #(
  parameter int unsigned AlphabetSize = mtfc_pkg::ALPHABET_SIZE
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_decode_mode_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [7:0]                        value_i,
  input  wire logic                              start_of_message_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [mtfc_pkg::VALUE_OUT_W-1:0]  value_out_o,
  output      logic                              error_o
);

`include "move_to_front_codec_top_defines.svh"

  localparam int unsigned SymW = $clog2(AlphabetSize);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic            decode_mode_q;
  logic            pass_q, pass_d;
  logic [SymW-1:0] key_q, key_d;
  logic [SymW-1:0] hold_val_q, hold_val_d;
  logic            hold_err_q, hold_err_d;
  logic            out_valid_q, out_valid_d;
  logic [mtfc_pkg::VALUE_OUT_W-1:0] value_out_q, value_out_d;
  logic            error_q, error_d;

  logic               in_xfer;
  logic               in_range;
  logic               out_free;
  logic               restore;
  mtfc_pkg::tok_ctl_t tok_in;
  mtfc_pkg::tok_ctl_t tok_tail;
  logic [SymW-1:0]    tail_result;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, value_i} < 9'(AlphabetSize);
  assign out_free   = !out_valid_q || out_ready_i;
  assign restore    = in_xfer && start_of_message_i;

  // Launch the token into the front cell
  always_comb begin
    tok_in            = '0;
    tok_in.valid      = (state_q == S_LAUNCH);
    tok_in.write_pass = pass_q;
  end

  mtfc_chain #(
    .AlphabetSize (AlphabetSize),
    .SymW         (SymW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restore_i (restore),
    .ctl_i     (tok_in),
    .key_i     (key_q),
    .carry_i   (key_q),
    .ctl_o     (tok_tail),
    .result_o  (tail_result)
  );

  // Sequence one item through the chain
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    key_d       = key_q;
    hold_val_d  = hold_val_q;
    hold_err_d  = hold_err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_out_d = value_out_q;
    error_d     = error_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          key_d  = value_i[SymW-1:0];
          pass_d = !decode_mode_q;
          if (in_range) begin
            state_d = S_LAUNCH;
          end else begin
            hold_val_d = '0;
            hold_err_d = decode_mode_q;
            state_d    = S_HOLD;
          end
        end
      end
      S_LAUNCH: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        if (tok_tail.valid) begin
          if (!pass_q) begin
            // lookup done: move the found symbol to the front
            key_d   = tail_result;
            pass_d  = 1'b1;
            state_d = S_LAUNCH;
          end else begin
            // decode answers with the symbol it moved, encode with its position
            hold_val_d = decode_mode_q ? key_q : tail_result;
            hold_err_d = 1'b0;
            state_d    = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_out_d = mtfc_pkg::VALUE_OUT_W'(hold_val_q);
          error_d     = hold_err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state and mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      decode_mode_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        decode_mode_q <= cfg_decode_mode_i;
      end
    end
  end

  // Hold item and result payload
  always_ff @(posedge clk_i) begin
    pass_q      <= pass_d;
    key_q       <= key_d;
    hold_val_q  <= hold_val_d;
    hold_err_q  <= hold_err_d;
    value_out_q <= value_out_d;
    error_q     <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign error_o     = error_q;

  `MTFC_ASSERT_NOW(a_err_zero_value, out_valid_o && error_o, value_out_o == '0)
  `MTFC_ASSERT_NEXT(a_one_item_at_a_time, in_xfer, !in_ready_o)
  `MTFC_ASSERT_NOW(a_tail_only_in_run, tok_tail.valid, state_q == S_RUN)

endmodule

`default_nettype wire
